>>> rtl/cdfd_pkg.sv
`default_nettype none
package cdfd_pkg;

   localparam int ID_W       = 11;
   localparam int LEN_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int VAL_W      = 13;
   localparam int LINE_W     = 128;
   localparam int HALF_W     = 64;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 136;
   localparam int RSP_USER_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_SPEED,
      KIND_GEAR,
      KIND_RPM,
      KIND_TEMP,
      KIND_IND
   } kind_type;

   // one classified frame, front to back
   typedef struct packed {
      kind_type           kind;
      logic [VAL_W-1:0]   value;
      logic [BYTE_W-1:0]  code;
   } entry_type;

   localparam logic [CSR_IDX_W-1:0] REG_SPEED_ID    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GEAR_ID     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RPM_ID      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_ID     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IND_ID      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OVERHEAT    = 3'd5;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_LINE1 = 2'd1;
   localparam logic [1:0] ACT_LINE2 = 2'd2;

   localparam logic [1:0] IND_OFF   = 2'd0;
   localparam logic [1:0] IND_LEFT  = 2'd1;
   localparam logic [1:0] IND_RIGHT = 2'd2;

   localparam logic [ID_W-1:0]   SPEED_ID_RESET = 11'd1;
   localparam logic [ID_W-1:0]   GEAR_ID_RESET  = 11'd2;
   localparam logic [ID_W-1:0]   RPM_ID_RESET   = 11'd3;
   localparam logic [ID_W-1:0]   TEMP_ID_RESET  = 11'd4;
   localparam logic [ID_W-1:0]   IND_ID_RESET   = 11'd5;
   localparam logic [BYTE_W-1:0] OVERHEAT_RESET = 8'd105;

   localparam logic [VAL_W-1:0] SPEED_MAX = 13'd200;
   localparam logic [VAL_W-1:0] RPM_MAX   = 13'd8000;
   localparam logic [VAL_W-1:0] TEMP_MAX  = 13'd130;
   localparam logic [VAL_W-1:0] TEMP_MIN  = 13'd30;

   localparam logic [BYTE_W-1:0] CHAR_N    = "N";
   localparam logic [BYTE_W-1:0] CHAR_R    = "R";
   localparam logic [BYTE_W-1:0] CHAR_ZERO = "0";
   localparam logic [BYTE_W-1:0] CHAR_ONE  = "1";
   localparam logic [BYTE_W-1:0] CHAR_SIX  = "6";

   // char 0 sits in the top byte
   localparam logic [LINE_W-1:0] LINE_ONE_INIT = "SPD:000 GR:N    ";
   localparam logic [LINE_W-1:0] LINE_TWO_INIT = "RPM:0000 T:030C ";

endpackage
`default_nettype wire

>>> rtl/cdfd_front.sv
`default_nettype none
module cdfd_front import cdfd_pkg::*; (
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [ID_W-1:0]       speed_id,
   input  wire logic [ID_W-1:0]       gear_id,
   input  wire logic [ID_W-1:0]       rpm_id,
   input  wire logic [ID_W-1:0]       temp_id,
   input  wire logic [ID_W-1:0]       ind_id,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output entry_type                  push_data
);

   logic [ID_W-1:0]     frame_id;
   logic [LEN_W-1:0]    frame_length;
   logic [BYTE_W-1:0]   payload_low;
   logic [BYTE_W-1:0]   payload_high;
   logic [2*BYTE_W-1:0] word;
   logic                long_frame;

   assign frame_id     = req_tdata[10:0];
   assign frame_length = req_tdata[14:11];
   assign payload_low  = req_tdata[22:15];
   assign payload_high = req_tdata[30:23];
   assign word         = {payload_high, payload_low};
   assign long_frame   = frame_length >= 4'd2;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_data.kind  = KIND_NONE;
      push_data.value = '0;
      push_data.code  = payload_low;
      if (frame_length != '0) begin
         if (frame_id == speed_id) begin
            if (long_frame) begin
               push_data.kind  = KIND_SPEED;
               push_data.value = (word > 16'(SPEED_MAX)) ? SPEED_MAX : word[VAL_W-1:0];
            end
         end else if (frame_id == gear_id) begin
            push_data.kind = KIND_GEAR;
            if (!(payload_low inside {CHAR_N, CHAR_R, [CHAR_ONE:CHAR_SIX]})) begin
               push_data.code = CHAR_N;
            end
         end else if (frame_id == rpm_id) begin
            if (long_frame) begin
               push_data.kind  = KIND_RPM;
               push_data.value = (word > 16'(RPM_MAX)) ? RPM_MAX : word[VAL_W-1:0];
            end
         end else if (frame_id == temp_id) begin
            if (long_frame) begin
               push_data.kind = KIND_TEMP;
               if (word > 16'(TEMP_MAX)) begin
                  push_data.value = TEMP_MAX;
               end else if (word < 16'(TEMP_MIN)) begin
                  push_data.value = TEMP_MIN;
               end else begin
                  push_data.value = word[VAL_W-1:0];
               end
            end
         end else if (frame_id == ind_id) begin
            // codes above right are left unclassified (kind none)
            if (payload_low <= 8'(IND_RIGHT)) begin
               push_data.kind = KIND_IND;
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/cdfd_queue.sv
`default_nettype none
module cdfd_queue import cdfd_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic      push_ready,
   input  wire entry_type push_data,
   output logic      pop_valid,
   input  wire logic pop_ready,
   output entry_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/cdfd_back.sv
`default_nettype none
module cdfd_back import cdfd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire entry_type             pop_data,
   input  wire logic [BYTE_W-1:0]     overheat_limit,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [RSP_USER_W-1:0]      rsp_tuser
);

   function automatic logic [LINE_W-1:0] put_char(input logic [LINE_W-1:0] line,
                                                  input int unsigned pos,
                                                  input logic [BYTE_W-1:0] c);
      logic [LINE_W-1:0] l;
      l = line;
      l[LINE_W-1-8*pos -: 8] = c;
      return l;
   endfunction

   function automatic logic [BYTE_W-1:0] ascii(input logic [3:0] d);
      return CHAR_ZERO + {4'd0, d};
   endfunction

   // digit stage: thousands and hundreds
   logic [3:0]  th_a, hu_a;
   logic [9:0]  rem_a;
   logic [15:0] hu_prod;
   logic [6:0]  r2_a;

   entry_type   b1_entry_ff;
   logic [3:0]  b1_th_ff, b1_hu_ff;
   logic [6:0]  b1_r2_ff;
   logic        b1_valid_ff, b1_valid_in;

   // update stage: tens and ones, state, result register
   logic [14:0] te_prod;
   logic [3:0]  te_b, on_b;

   logic [LINE_W-1:0] line1_ff, line1_in;
   logic [LINE_W-1:0] line2_ff, line2_in;
   logic              led_ff, led_in;
   logic [1:0]        ind_ff, ind_in;

   logic              out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic [RSP_USER_W-1:0] out_user_ff, out_user_in;
   logic              out_free, advance;
   logic [1:0]        action;
   logic              left_off, right_off;
   logic [LINE_W-1:0] shown;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign advance   = b1_valid_ff && out_free;
   assign pop_ready = !b1_valid_ff || out_free;

   always_comb begin
      th_a = '0;
      for (int k = 1; k <= 8; k++) begin
         if (pop_data.value >= VAL_W'(k * 1000)) begin
            th_a = 4'(k);
         end
      end
      rem_a   = 10'(pop_data.value - 13'(th_a) * 13'd1000);
      hu_prod = 16'(rem_a) * 16'd41;
      hu_a    = 4'(hu_prod >> 12);
      r2_a    = 7'(rem_a - 10'(hu_a) * 10'd100);
   end

   assign b1_valid_in = pop_ready ? pop_valid : b1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         b1_entry_ff <= pop_data;
         b1_th_ff    <= th_a;
         b1_hu_ff    <= hu_a;
         b1_r2_ff    <= r2_a;
      end
   end

   always_comb begin
      te_prod   = 15'(b1_r2_ff) * 15'd205;
      te_b      = 4'(te_prod >> 11);
      on_b      = 4'(b1_r2_ff - 7'(te_b) * 7'd10);
      line1_in  = line1_ff;
      line2_in  = line2_ff;
      led_in    = led_ff;
      ind_in    = ind_ff;
      action    = ACT_NONE;
      left_off  = 1'b0;
      right_off = 1'b0;
      case (b1_entry_ff.kind)
         KIND_SPEED: begin
            line1_in = put_char(line1_in, 4, ascii(b1_hu_ff));
            line1_in = put_char(line1_in, 5, ascii(te_b));
            line1_in = put_char(line1_in, 6, ascii(on_b));
            action   = ACT_LINE1;
         end
         KIND_GEAR: begin
            line1_in = put_char(line1_ff, 11, b1_entry_ff.code);
            action   = ACT_LINE1;
         end
         KIND_RPM: begin
            line2_in = put_char(line2_in, 4, ascii(b1_th_ff));
            line2_in = put_char(line2_in, 5, ascii(b1_hu_ff));
            line2_in = put_char(line2_in, 6, ascii(te_b));
            line2_in = put_char(line2_in, 7, ascii(on_b));
            action   = ACT_LINE2;
         end
         KIND_TEMP: begin
            line2_in = put_char(line2_in, 11, ascii(b1_hu_ff));
            line2_in = put_char(line2_in, 12, ascii(te_b));
            line2_in = put_char(line2_in, 13, ascii(on_b));
            action   = ACT_LINE2;
            if (b1_entry_ff.value > VAL_W'(overheat_limit)) begin
               led_in = 1'b1;
            end
         end
         KIND_IND: begin
            // the side lit before goes dark; off darkens both
            left_off  = (ind_ff == IND_LEFT)  || (b1_entry_ff.code[1:0] == IND_OFF);
            right_off = (ind_ff == IND_RIGHT) || (b1_entry_ff.code[1:0] == IND_OFF);
            ind_in    = b1_entry_ff.code[1:0];
            led_in    = b1_entry_ff.code[1:0] != IND_OFF;
         end
         default: begin
         end
      endcase
      case (action)
         ACT_LINE1: shown = line1_in;
         ACT_LINE2: shown = line2_in;
         default:   shown = '0;
      endcase
      out_data_in = {3'd0, right_off, left_off, ind_in, led_in,
                     shown[HALF_W-1:0], shown[LINE_W-1:HALF_W]};
      out_user_in = action;
      out_valid_in = out_free ? b1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line1_ff     <= LINE_ONE_INIT;
         line2_ff     <= LINE_TWO_INIT;
         led_ff       <= 1'b0;
         ind_ff       <= IND_OFF;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            line1_ff <= line1_in;
            line2_ff <= line2_in;
            led_ff   <= led_in;
            ind_ff   <= ind_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule
`default_nettype wire

>>> rtl/can_dashboard_frame_decoder_top.sv
// channel | direction | handshake              | payload
// req     | in        | req_tvalid/req_tready  | req_tdata: one CAN frame word
// rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata, rsp_tuser: display result
// csr     | in        | csr_valid/csr_ready    | csr_index, csr_data: register write
//
// One frame per cycle sustained while rsp is not stalled. An accepted frame moves
// through the queue slot, digit stage (thousands/hundreds) and update stage into the
// result register. Thousands by compare, hundreds and tens by reciprocal multiply.
// Reset restores both text lines, LED and indicator, and all ids.
// A stalled rsp fills the result register, the digit stage and then the queue;
// req_tready drops only when the queue is full.
`default_nettype none
module can_dashboard_frame_decoder_top import cdfd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // frame_id[10:0], frame_length[14:11], payload_low[22:15], payload_high[30:23]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // text_left_half[63:0], text_right_half[127:64], warning_armed[128],
   // indicator_mode[130:129], left_lamp_off[131], right_lamp_off[132]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // line_action[1:0]
   output logic [RSP_USER_W-1:0]      rsp_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic [ID_W-1:0]   speed_id_ff, gear_id_ff, rpm_id_ff, temp_id_ff, ind_id_ff;
   logic [BYTE_W-1:0] overheat_ff;

   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_data, pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_id_ff <= SPEED_ID_RESET;
         gear_id_ff  <= GEAR_ID_RESET;
         rpm_id_ff   <= RPM_ID_RESET;
         temp_id_ff  <= TEMP_ID_RESET;
         ind_id_ff   <= IND_ID_RESET;
         overheat_ff <= OVERHEAT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SPEED_ID: speed_id_ff <= csr_data;
            REG_GEAR_ID:  gear_id_ff  <= csr_data;
            REG_RPM_ID:   rpm_id_ff   <= csr_data;
            REG_TEMP_ID:  temp_id_ff  <= csr_data;
            REG_IND_ID:   ind_id_ff   <= csr_data;
            REG_OVERHEAT: overheat_ff <= csr_data[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cdfd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .speed_id   (speed_id_ff),
      .gear_id    (gear_id_ff),
      .rpm_id     (rpm_id_ff),
      .temp_id    (temp_id_ff),
      .ind_id     (ind_id_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   cdfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cdfd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .overheat_limit (overheat_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser)
   );

   // an active indicator always leaves the LED armed
   a_ind_arms_led: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[130:129] != IND_OFF) |-> rsp_tdata[128])
      else $error("indicator active with LED disarmed");

   a_no_line_no_text: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ACT_NONE) |-> (rsp_tdata[127:0] == '0))
      else $error("text present without line update");

   a_both_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[131] && rsp_tdata[132]
      |-> (rsp_tdata[130:129] == IND_OFF) && !rsp_tdata[128])
      else $error("both lamps off but indicator or LED still on");

   a_line1_label: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ACT_LINE1) |-> (rsp_tdata[63:32] == 32'("SPD:")))
      else $error("first line label corrupted");

endmodule
`default_nettype wire
